>>> sv/thick_line_bitmap_rasterizer_macros.svh
// Assertion macros used by the rasterizer checker.
`ifndef THICK_LINE_BITMAP_RASTERIZER_MACROS_SVH
`define THICK_LINE_BITMAP_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TLBR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TLBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tlbr_pkg.sv
// Package: constants, codes and shared types of the thick line rasterizer.
package tlbr_pkg;

   localparam int GRID_W     = 16;
   localparam int GRID_H     = 32;
   localparam int ROW_IDX_W  = $clog2(GRID_H);
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 7;
   localparam int THICK_W    = 3;
   localparam int READ_ROW_W = 5;
   localparam int OUT_W      = 16;
   localparam int COPY_W     = (GRID_W < OUT_W) ? GRID_W : OUT_W;
   localparam int H_W        = THICK_W - 1;
   localparam int OFF_W      = H_W + 1;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int POS_W      = COORD_W + 1;
   localparam int ERR_W      = COORD_W + 3;
   localparam int E2_W       = ERR_W + 1;
   localparam int COL_D_W    = COORD_W + 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_DRAIN,
      ST_RD_WAIT
   } top_state_type;

   typedef struct packed {
      logic                      go;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic [H_W-1:0]            h;
   } walk_start_type;

   typedef struct packed {
      logic                 vld;
      logic                 last;
      logic [ROW_IDX_W-1:0] row;
      logic [GRID_W-1:0]    mask;
   } row_req_type;

   // Largest column offset kept by the disc brush on a brush row |oy| = ay
   function automatic logic [H_W-1:0] half_width(input logic [H_W-1:0] h,
                                                 input logic [H_W-1:0] ay);
      logic [H_W-1:0] w;
      w = '0;
      case ({h, ay})
         {2'd1, 2'd0}: w = 2'd1;
         {2'd1, 2'd1}: w = 2'd1;
         {2'd2, 2'd0}: w = 2'd2;
         {2'd2, 2'd1}: w = 2'd2;
         {2'd2, 2'd2}: w = 2'd1;
         {2'd3, 2'd0}: w = 2'd3;
         {2'd3, 2'd1}: w = 2'd3;
         {2'd3, 2'd2}: w = 2'd2;
         {2'd3, 2'd3}: w = 2'd1;
         default:      w = '0;
      endcase
      return w;
   endfunction

endpackage

>>> sv/tlbr_req_if.sv
// Command channel interface: valid/ready handshake with the command item.
interface tlbr_req_if;
   import tlbr_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CMD_W-1:0]             cmd;
   logic signed [COORD_W-1:0]    x_start;
   logic signed [COORD_W-1:0]    y_start;
   logic signed [COORD_W-1:0]    x_end;
   logic signed [COORD_W-1:0]    y_end;
   logic [THICK_W-1:0]           thickness;
   logic [READ_ROW_W-1:0]        read_row;

   modport source (output valid, cmd, x_start, y_start, x_end, y_end, thickness, read_row,
                   input ready);
   modport sink (input valid, cmd, x_start, y_start, x_end, y_end, thickness, read_row,
                 output ready);
endinterface

>>> sv/tlbr_rsp_if.sv
// Result channel interface: valid/ready handshake with one bitmap row.
interface tlbr_rsp_if;
   import tlbr_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] row_bits;

   modport source (output valid, row_bits, input ready);
   modport sink (input valid, row_bits, output ready);
endinterface

>>> sv/tlbr_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module tlbr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/tlbr_line_walker.sv
// Bresenham walker: issues one brush row (row index and column mask) per cycle.
module tlbr_line_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  tlbr_pkg::walk_start_type start,
   output tlbr_pkg::row_req_type    row_req
);
   import tlbr_pkg::*;

   logic                      active_ff, active_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [COORD_W-1:0] x1_ff, x1_in;
   logic signed [COORD_W-1:0] y1_ff, y1_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in;
   logic signed [DIFF_W-1:0]  dy_ff, dy_in;
   logic                      sx_neg_ff, sx_neg_in;
   logic                      sy_neg_ff, sy_neg_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [OFF_W-1:0]   oy_ff, oy_in;
   logic [H_W-1:0]            h_ff, h_in;

   logic signed [POS_W-1:0]   row_pos;
   logic                      row_in_range;
   logic [H_W-1:0]            ay;
   logic [H_W-1:0]            w;
   logic signed [COL_D_W-1:0] w_s;
   logic signed [COL_D_W-1:0] col_d;
   logic [GRID_W-1:0]         mask;
   logic signed [OFF_W-1:0]   h_s;
   logic                      oy_last;
   logic                      at_end;
   logic signed [E2_W-1:0]    e2;
   logic signed [ERR_W-1:0]   nerr;
   logic signed [DIFF_W-1:0]  dx_raw;
   logic signed [DIFF_W-1:0]  dy_raw;

   always_comb begin
      row_pos      = POS_W'(cy_ff) + POS_W'(oy_ff);
      row_in_range = (row_pos >= 0) && (int'(row_pos) < GRID_H);
      ay           = oy_ff[OFF_W-1] ? H_W'(-oy_ff) : H_W'(oy_ff);
      w            = half_width(h_ff, ay);
      w_s          = $signed(COL_D_W'(w));
      mask         = '0;
      for (int c = 0; c < GRID_W; c++) begin
         col_d   = COL_D_W'(c) - COL_D_W'(cx_ff);
         mask[c] = (col_d >= -w_s) && (col_d <= w_s);
      end
      h_s     = $signed(OFF_W'(h_ff));
      oy_last = (oy_ff == h_s);
      at_end  = (cx_ff == x1_ff) && (cy_ff == y1_ff);

      row_req.vld  = active_ff && row_in_range;
      row_req.last = active_ff && oy_last && at_end;
      row_req.row  = ROW_IDX_W'(row_pos);
      row_req.mask = mask;

      e2   = {E2_W'(err_ff)} <<< 1;
      nerr = err_ff;

      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      err_in    = err_ff;
      oy_in     = oy_ff;
      h_in      = h_ff;

      dx_raw = DIFF_W'(start.x1) - DIFF_W'(start.x0);
      dy_raw = DIFF_W'(start.y1) - DIFF_W'(start.y0);

      if (start.go) begin
         active_in = 1'b1;
         cx_in     = start.x0;
         cy_in     = start.y0;
         x1_in     = start.x1;
         y1_in     = start.y1;
         dx_in     = (dx_raw < 0) ? -dx_raw : dx_raw;
         dy_in     = (dy_raw < 0) ? dy_raw : -dy_raw;
         sx_neg_in = !(start.x0 < start.x1);
         sy_neg_in = !(start.y0 < start.y1);
         err_in    = ERR_W'(dx_in) + ERR_W'(dy_in);
         h_in      = start.h;
         oy_in     = -$signed(OFF_W'(start.h));
      end else if (active_ff) begin
         if (!oy_last) begin
            oy_in = oy_ff + OFF_W'(1);
         end else if (at_end) begin
            active_in = 1'b0;
         end else begin
            if (e2 >= E2_W'(dy_ff)) begin
               nerr  = nerr + ERR_W'(dy_ff);
               cx_in = cx_ff + (sx_neg_ff ? COORD_W'(-1) : COORD_W'(1));
            end
            if (e2 <= E2_W'(dx_ff)) begin
               nerr  = nerr + ERR_W'(dx_ff);
               cy_in = cy_ff + (sy_neg_ff ? COORD_W'(-1) : COORD_W'(1));
            end
            err_in = nerr;
            oy_in  = -h_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      err_ff    <= err_in;
      oy_ff     <= oy_in;
      h_ff      <= h_in;
   end
endmodule

>>> sv/thick_line_bitmap_rasterizer.sv
// Top level: command sequencing, bitmap read-modify-write and the result register.
//
//   channel | dir | handshake        | payload
//   req_ch  | in  | valid && ready   | cmd, x_start, y_start, x_end, y_end, thickness, read_row
//   rsp_ch  | out | valid && ready   | row_bits
//
// Clear and unused commands finish on acceptance; a read also waits out any stall on rsp_ch.
// A draw walks 2*h + 1 brush rows per point: the walker issues one brush row per cycle
// into the bitmap RAM, read one cycle and written the next, with forwarding on a repeated row.
// Reset and clear empty the bitmap at once through per-row valid bits; no clearing pass.
// A waiting result does not block clear or draw items.
module thick_line_bitmap_rasterizer (
   input logic        clock,
   input logic        reset,
   tlbr_req_if.sink   req_ch,
   tlbr_rsp_if.source rsp_ch
);
   import tlbr_pkg::*;

   top_state_type        state_ff, state_in;
   logic [GRID_H-1:0]    row_vld_ff, row_vld_in;
   logic                 wr_vld_ff;
   logic [ROW_IDX_W-1:0] wr_row_ff;
   logic [GRID_W-1:0]    wr_mask_ff;
   logic                 fwd_ff;
   logic                 old_vld_ff;
   logic [GRID_W-1:0]    last_wr_ff;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0]     rsp_bits_ff, rsp_bits_in;

   logic                 accept;
   cmd_type              cmd;
   logic                 read_in_range;
   logic [ROW_IDX_W-1:0] read_addr;
   logic                 load_rsp;
   logic [GRID_W-1:0]    base;
   logic [OUT_W-1:0]     rd_bits;

   walk_start_type       walk_start;
   row_req_type          row_req;

   logic                 ram_wr_en;
   logic [ROW_IDX_W-1:0] ram_wr_addr;
   logic [GRID_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [ROW_IDX_W-1:0] ram_rd_addr;
   logic [GRID_W-1:0]    ram_rd_data;

   tlbr_line_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .row_req (row_req)
   );

   tlbr_ram #(
      .WIDTH (GRID_W),
      .DEPTH (GRID_H)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      req_ch.ready  = (state_ff == ST_IDLE);
      accept        = req_ch.valid && req_ch.ready;
      cmd           = cmd_type'(req_ch.cmd);
      read_in_range = int'(req_ch.read_row) < GRID_H;
      read_addr     = ROW_IDX_W'(req_ch.read_row);

      walk_start.go = accept && (cmd == CMD_DRAW);
      walk_start.x0 = req_ch.x_start;
      walk_start.y0 = req_ch.y_start;
      walk_start.x1 = req_ch.x_end;
      walk_start.y1 = req_ch.y_end;
      walk_start.h  = req_ch.thickness[THICK_W-1:1];

      // write half of the read-modify-write
      base        = fwd_ff ? last_wr_ff : (old_vld_ff ? ram_rd_data : '0);
      ram_wr_en   = wr_vld_ff;
      ram_wr_addr = wr_row_ff;
      ram_wr_data = base | wr_mask_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = row_req.row;
      if (row_req.vld) begin
         ram_rd_en = 1'b1;
      end else if (accept && (cmd == CMD_READ) && read_in_range) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = read_addr;
      end

      row_vld_in = row_vld_ff;
      if (wr_vld_ff) begin
         row_vld_in[wr_row_ff] = 1'b1;
      end
      if (accept && (cmd == CMD_CLEAR)) begin
         row_vld_in = '0;
      end

      rd_ok_in = rd_ok_ff;
      if (accept && (cmd == CMD_READ)) begin
         rd_ok_in = read_in_range && row_vld_ff[read_addr];
      end

      rd_bits = '0;
      for (int i = 0; i < COPY_W; i++) begin
         rd_bits[i] = ram_rd_data[i];
      end

      state_in = state_ff;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_DRAW: state_in = ST_DRAW;
                  CMD_READ: state_in = ST_RD_WAIT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_DRAW: begin
            if (row_req.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_RD_WAIT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_vld_in  = load_rsp || (rsp_vld_ff && !rsp_ch.ready);
      rsp_bits_in = load_rsp ? (rd_ok_ff ? rd_bits : '0) : rsp_bits_ff;

      rsp_ch.valid    = rsp_vld_ff;
      rsp_ch.row_bits = rsp_bits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_vld_ff <= '0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_vld_ff <= row_vld_in;
         wr_vld_ff  <= row_req.vld;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_row_ff   <= row_req.row;
      wr_mask_ff  <= row_req.mask;
      fwd_ff      <= wr_vld_ff && (wr_row_ff == row_req.row);
      old_vld_ff  <= row_vld_ff[row_req.row];
      last_wr_ff  <= ram_wr_data;
      rd_ok_ff    <= rd_ok_in;
      rsp_bits_ff <= rsp_bits_in;
   end
endmodule

>>> sv/tlbr_checker.sv
// Port-level checker for the rasterizer, bound to the top level.
`include "thick_line_bitmap_rasterizer_macros.svh"

module tlbr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [tlbr_pkg::CMD_W-1:0]     req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tlbr_pkg::OUT_W-1:0]     rsp_row_bits
);
   import tlbr_pkg::*;

   logic req_acc;
   logic busy_cmd;

   assign req_acc  = req_valid && req_ready;
   assign busy_cmd = (req_cmd == CMD_DRAW) || (req_cmd == CMD_READ);

   `TLBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_bits), "result item dropped or changed while stalled")
   `TLBR_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "block not idle and empty after reset")
   `TLBR_ASSERT_NEXT(a_busy_after, clock, reset, req_acc && busy_cmd, !req_ready, "draw or read item did not hold off the next item")
   `TLBR_ASSERT_NEXT(a_no_spurious, clock, reset, req_acc && (req_cmd != CMD_READ) && !rsp_valid, !rsp_valid ##1 !rsp_valid, "result item without a read item")
endmodule

bind thick_line_bitmap_rasterizer tlbr_checker u_tlbr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_cmd      (req_ch.cmd),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_row_bits (rsp_ch.row_bits)
);
